[rtl/kabf_pkg.sv]
package kabf_pkg;

	localparam int DEF_ANGLE_FRAC_BITS = 20;
	localparam int DEF_COV_WIDTH = 48;
	localparam int DT_FRAC = 24;
	localparam int NOISE_FRAC = 32;
	localparam int GAIN_FRAC = 32;
	localparam int DIV_STEPS = 64 + GAIN_FRAC;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd2;

	localparam logic [31:0] RST_ANGLE_NOISE = 32'd4294967;
	localparam logic [31:0] RST_BIAS_NOISE = 32'd12884902;
	localparam logic [31:0] RST_MEAS_NOISE = 32'd128849019;

	localparam int STATE_W = 5;
	localparam logic [STATE_W-1:0] ST_IDLE = 5'd0;
	localparam logic [STATE_W-1:0] ST_RATE = 5'd1;
	localparam logic [STATE_W-1:0] ST_M_ANG = 5'd2;
	localparam logic [STATE_W-1:0] ST_M_DTP = 5'd3;
	localparam logic [STATE_W-1:0] ST_T2 = 5'd4;
	localparam logic [STATE_W-1:0] ST_T3 = 5'd5;
	localparam logic [STATE_W-1:0] ST_M_P0 = 5'd6;
	localparam logic [STATE_W-1:0] ST_M_P3 = 5'd7;
	localparam logic [STATE_W-1:0] ST_S = 5'd8;
	localparam logic [STATE_W-1:0] ST_D_K0 = 5'd9;
	localparam logic [STATE_W-1:0] ST_D_K1 = 5'd10;
	localparam logic [STATE_W-1:0] ST_M_ANG2 = 5'd11;
	localparam logic [STATE_W-1:0] ST_M_BIAS = 5'd12;
	localparam logic [STATE_W-1:0] ST_M_P2 = 5'd13;
	localparam logic [STATE_W-1:0] ST_M_P3B = 5'd14;
	localparam logic [STATE_W-1:0] ST_M_P0B = 5'd15;
	localparam logic [STATE_W-1:0] ST_M_P1B = 5'd16;
	localparam logic [STATE_W-1:0] ST_OUT = 5'd17;

	typedef struct packed {
		logic signed [31:0] measured_angle;
		logic signed [31:0] measured_rate;
		logic [23:0] time_step;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] angle_estimate;
		logic signed [31:0] corrected_rate;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic go_mul;
		logic go_div;
		logic wb;
		logic emit;
		logic [STATE_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic s_zero;
	} sts_t;

	function automatic logic [63:0] mag(input logic signed [63:0] a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	function automatic logic signed [63:0] mag_to_signed(input logic hi_nz,
			input logic [63:0] lo, input logic neg);
		if (!neg) begin
			return (hi_nz || lo[63]) ? {1'b0, {63{1'b1}}} : lo;
		end
		return (hi_nz || lo[63]) ? {1'b1, 63'd0} : 64'(-lo);
	endfunction

	function automatic logic signed [63:0] sat_w(input logic signed [64:0] x, input int w);
		logic signed [64:0] hi;
		logic signed [64:0] lo;
		hi = (65'sd1 <<< (w - 1)) - 65'sd1;
		lo = -hi - 65'sd1;
		if (x > hi) begin
			return hi[63:0];
		end
		if (x < lo) begin
			return lo[63:0];
		end
		return x[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
		logic signed [63:0] tmp;
		tmp = sat_w(x, 32);
		return tmp[31:0];
	endfunction

endpackage

[rtl/kabf_mul.sv]
module kabf_mul import kabf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	input  logic               gain_shift,
	output logic               done,
	output logic signed [63:0] result
);

	logic busy_q, done_q;
	logic [2:0] cnt_q;
	logic neg_q, sh32_q;
	logic [63:0] ua_q, ub_q;
	logic [63:0] pp_q;
	logic [1:0] off_q;
	logic [127:0] acc_q;
	logic signed [63:0] res_q;
	logic [31:0] a_part, b_part;
	logic [127:0] shifted;

	always_comb begin
		a_part = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		b_part = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		shifted = sh32_q ? (acc_q >> GAIN_FRAC) : (acc_q >> DT_FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ua_q <= mag(a);
			ub_q <= mag(b);
			neg_q <= a[63] ^ b[63];
			sh32_q <= gain_shift;
			acc_q <= '0;
		end else if (busy_q) begin
			if (!cnt_q[2]) begin
				pp_q <= 64'(a_part) * 64'(b_part);
				off_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
			end
			if (cnt_q != 3'd0 && cnt_q != 3'd5) begin
				acc_q <= acc_q + ({64'd0, pp_q} << {off_q, 5'd0});
			end
			if (cnt_q == 3'd5) begin
				res_q <= mag_to_signed(|shifted[127:64], shifted[63:0], neg_q);
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

[rtl/kabf_div.sv]
module kabf_div import kabf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [63:0] n,
	input  logic signed [63:0] d,
	output logic               done,
	output logic signed [63:0] result
);

	logic busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic neg_q, ovf_q;
	logic [DIV_STEPS-1:0] dvd_q;
	logic [63:0] ud_q, r_q, q_q;
	logic signed [63:0] res_q;
	logic [64:0] r2, diff;
	logic ge;

	always_comb begin
		r2 = {r_q, dvd_q[DIV_STEPS-1]};
		diff = r2 - {1'b0, ud_q};
		ge = (r2 >= {1'b0, ud_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= n[63] ^ d[63];
			dvd_q <= {mag(n), {GAIN_FRAC{1'b0}}};
			ud_q <= mag(d);
			r_q <= '0;
			q_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				dvd_q <= dvd_q << 1;
				ovf_q <= ovf_q | q_q[63];
				q_q <= {q_q[62:0], ge};
				r_q <= ge ? diff[63:0] : r2[63:0];
			end else begin
				res_q <= mag_to_signed(ovf_q, q_q, neg_q);
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

[rtl/kabf_datapath.sv]
module kabf_datapath import kabf_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int COV_WIDTH = DEF_COV_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  in_word_t             in_data,
	output out_word_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int COV_FRAC = 2 * ANGLE_FRAC_BITS;
	localparam int LSH = (COV_FRAC >= NOISE_FRAC) ? COV_FRAC - NOISE_FRAC : 0;
	localparam int RSH = (COV_FRAC >= NOISE_FRAC) ? 0 : NOISE_FRAC - COV_FRAC;

	function automatic logic signed [63:0] noise_cov(input logic [31:0] q);
		logic [63:0] tmp;
		tmp = {32'd0, q};
		return (tmp << LSH) >> RSH;
	endfunction

	function automatic logic signed [COV_WIDTH-1:0] cov_sat(input logic signed [64:0] x);
		logic signed [63:0] tmp;
		tmp = sat_w(x, COV_WIDTH);
		return tmp[COV_WIDTH-1:0];
	endfunction

	logic [31:0] q_angle_q, q_bias_q, r_meas_q;
	logic signed [31:0] z_q, w_q;
	logic [23:0] dt_q;
	logic signed [31:0] ang_q, bias_q, rate_q;
	logic signed [COV_WIDTH-1:0] p_q [4];
	logic signed [63:0] dtp_q, t_q, s_q, k0_q, k1_q;
	logic signed [32:0] y_q;
	out_word_t out_q;

	logic signed [63:0] pw [4];
	logic signed [63:0] nqa, nqb, nr;
	logic signed [63:0] ma, mb, m, dn, dq;
	logic mgain;
	logic m_done, d_done;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pw[i] = 64'(p_q[i]);
		end
		nqa = noise_cov(q_angle_q);
		nqb = noise_cov(q_bias_q);
		nr = noise_cov(r_meas_q);
		ma = '0;
		mb = '0;
		mgain = 1'b1;
		case (cmd.step)
			ST_M_ANG: begin
				ma = 64'(dt_q);
				mb = 64'(rate_q);
				mgain = 1'b0;
			end
			ST_M_DTP: begin
				ma = 64'(dt_q);
				mb = pw[3];
				mgain = 1'b0;
			end
			ST_M_P0: begin
				ma = 64'(dt_q);
				mb = t_q;
				mgain = 1'b0;
			end
			ST_M_P3: begin
				ma = nqb;
				mb = 64'(dt_q);
				mgain = 1'b0;
			end
			ST_M_ANG2: begin
				ma = k0_q;
				mb = 64'(y_q);
			end
			ST_M_BIAS: begin
				ma = k1_q;
				mb = 64'(y_q);
			end
			ST_M_P2: begin
				ma = k1_q;
				mb = pw[0];
			end
			ST_M_P3B: begin
				ma = k1_q;
				mb = pw[1];
			end
			ST_M_P0B: begin
				ma = k0_q;
				mb = pw[0];
			end
			ST_M_P1B: begin
				ma = k0_q;
				mb = pw[1];
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		dn = (cmd.step == ST_D_K1) ? pw[2] : pw[0];
		sts.mul_done = m_done;
		sts.div_done = d_done;
		sts.s_zero = (s_q == '0);
	end

	kabf_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.go(cmd.go_mul),
		.a(ma),
		.b(mb),
		.gain_shift(mgain),
		.done(m_done),
		.result(m)
	);

	kabf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(cmd.go_div),
		.n(dn),
		.d(s_q),
		.done(d_done),
		.result(dq)
	);

	// config and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q <= RST_ANGLE_NOISE;
			q_bias_q <= RST_BIAS_NOISE;
			r_meas_q <= RST_MEAS_NOISE;
			ang_q <= '0;
			bias_q <= '0;
			for (int i = 0; i < 4; i++) begin
				p_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ANGLE_NOISE: q_angle_q <= cfg_data;
					CFG_BIAS_NOISE: q_bias_q <= cfg_data;
					CFG_MEAS_NOISE: r_meas_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.wb) begin
				case (cmd.step)
					ST_M_ANG: ang_q <= sat32(65'(ang_q) + 65'(m));
					ST_T3: begin
						p_q[1] <= cov_sat(65'(pw[1]) - 65'(dtp_q));
						p_q[2] <= cov_sat(65'(pw[2]) - 65'(dtp_q));
					end
					ST_M_P0: p_q[0] <= cov_sat(65'(pw[0]) + 65'(m));
					ST_M_P3: p_q[3] <= cov_sat(65'(pw[3]) + 65'(m));
					ST_M_ANG2: ang_q <= sat32(65'(ang_q) + 65'(m));
					ST_M_BIAS: bias_q <= sat32(65'(bias_q) + 65'(m));
					ST_M_P2: p_q[2] <= cov_sat(65'(pw[2]) - 65'(m));
					ST_M_P3B: p_q[3] <= cov_sat(65'(pw[3]) - 65'(m));
					ST_M_P0B: p_q[0] <= cov_sat(65'(pw[0]) - 65'(m));
					ST_M_P1B: p_q[1] <= cov_sat(65'(pw[1]) - 65'(m));
					default: ;
				endcase
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			z_q <= in_data.measured_angle;
			w_q <= in_data.measured_rate;
			dt_q <= in_data.time_step;
		end
		if (cmd.emit) begin
			out_q.angle_estimate <= ang_q;
			out_q.corrected_rate <= rate_q;
		end
		if (cmd.wb) begin
			case (cmd.step)
				ST_RATE: rate_q <= sat32(65'(w_q) - 65'(bias_q));
				ST_M_DTP: begin
					dtp_q <= m;
					t_q <= sat_w(65'(m) - 65'(pw[1]), 64);
				end
				ST_T2: t_q <= sat_w(65'(t_q) - 65'(pw[2]), 64);
				ST_T3: t_q <= sat_w(65'(t_q) + 65'(nqa), 64);
				ST_S: begin
					s_q <= sat_w(65'(pw[0]) + 65'(nr), 64);
					y_q <= 33'(z_q) - 33'(ang_q);
				end
				ST_D_K0: begin
					k0_q <= sts.s_zero ? '0 : dq;
					if (sts.s_zero) begin
						k1_q <= '0;
					end
				end
				ST_D_K1: k1_q <= dq;
				default: ;
			endcase
		end
	end

	assign out_data = out_q;

endmodule

[rtl/kabf_ctrl.sv]
module kabf_ctrl import kabf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	logic [STATE_W-1:0] state_q, state_nxt;
	logic issued_q, issued_nxt;
	logic out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.step = state_q;
		state_nxt = state_q;
		issued_nxt = issued_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nxt = ST_RATE;
				end
			end
			ST_RATE, ST_T2, ST_T3, ST_S: begin
				cmd.wb = 1'b1;
				state_nxt = state_q + 1'b1;
			end
			ST_M_ANG, ST_M_DTP, ST_M_P0, ST_M_P3, ST_M_ANG2, ST_M_BIAS,
			ST_M_P2, ST_M_P3B, ST_M_P0B, ST_M_P1B: begin
				if (!issued_q) begin
					cmd.go_mul = 1'b1;
					issued_nxt = 1'b1;
				end else if (sts.mul_done) begin
					cmd.wb = 1'b1;
					issued_nxt = 1'b0;
					state_nxt = state_q + 1'b1;
				end
			end
			ST_D_K0, ST_D_K1: begin
				if (state_q == ST_D_K0 && sts.s_zero) begin
					cmd.wb = 1'b1;
					state_nxt = ST_M_ANG2;
				end else if (!issued_q) begin
					cmd.go_div = 1'b1;
					issued_nxt = 1'b1;
				end else if (sts.div_done) begin
					cmd.wb = 1'b1;
					issued_nxt = 1'b0;
					state_nxt = state_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
				issued_nxt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			issued_q <= issued_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/kalman_angle_bias_filter.sv]
// channel  dir  handshake                payload
// in       in   in_valid / in_stall      in_data   (in_word_t)
// out      out  out_valid / out_stall    out_data  (out_word_t)
// cfg      in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// each word takes two 96-step bit-serial gain divisions and ten passes of the shared 32x32
// multiplier (four partial products each); when the innovation variance is zero the
// divisions are skipped and both gains are zero
// one word in flight; the next is taken once the result sits in the output register
// reset clears angle, bias and covariance and loads the default noise registers
// a stalled result holds the finished word until taken
module kalman_angle_bias_filter import kabf_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int COV_WIDTH = DEF_COV_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	kabf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts(sts),
		.cmd(cmd)
	);

	kabf_datapath #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.COV_WIDTH(COV_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_data(in_data),
		.out_data(out_data),
		.cfg_we(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

endmodule

[test/kalman_angle_bias_filter_tb.sv]
module kalman_angle_bias_filter_tb;
	import kabf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [63:0] s64;
	typedef logic signed [64:0] s65;

	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

	class tilt_scoreboard;
		logic [31:0] q_angle, q_bias, r_meas;
		s64 angle_est, bias_est;
		s64 cov [4];
		out_word_t pending [$];
		int errors;

		function new();
			q_angle = RST_ANGLE_NOISE;
			q_bias = RST_BIAS_NOISE;
			r_meas = RST_MEAS_NOISE;
			angle_est = 0;
			bias_est = 0;
			foreach (cov[i]) cov[i] = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				CFG_ANGLE_NOISE: q_angle = val;
				CFG_BIAS_NOISE: q_bias = val;
				CFG_MEAS_NOISE: r_meas = val;
				default: ;
			endcase
		endfunction

		function logic [63:0] magn(s64 a);
			return a[63] ? 64'(-a) : 64'(a);
		endfunction

		function s64 to_signed(logic [127:0] m, logic neg);
			if (!neg) begin
				return (m > 128'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : s64'(m[63:0]);
			end
			return (m >= 128'h8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000
				: s64'(-m[63:0]);
		endfunction

		function s64 clamp(s65 x, int w);
			s65 hi;
			s65 lo;
			hi = (65'sd1 <<< (w - 1)) - 65'sd1;
			lo = -hi - 65'sd1;
			if (x > hi) return hi[63:0];
			if (x < lo) return lo[63:0];
			return x[63:0];
		endfunction

		function s64 sadd(s64 a, s64 b);
			s65 x;
			x = {a[63], a} + {b[63], b};
			return clamp(x, 64);
		endfunction

		function s64 ssub(s64 a, s64 b);
			s65 x;
			x = {a[63], a} - {b[63], b};
			return clamp(x, 64);
		endfunction

		function s64 mul_shift(s64 a, s64 b, int sh);
			logic [127:0] m;
			m = ({64'd0, magn(a)} * {64'd0, magn(b)}) >> sh;
			return to_signed(m, a[63] ^ b[63]);
		endfunction

		function s64 div_shift(s64 n, s64 d, int sh);
			logic [127:0] m;
			m = ({64'd0, magn(n)} << sh) / {64'd0, magn(d)};
			return to_signed(m, n[63] ^ d[63]);
		endfunction

		function void note_input(in_word_t w);
			s64 z, gyro, dt, rate, t, dtp, s, k0, k1, y, a00, a01, qa, qb, rm;
			out_word_t res;
			z = s64'(w.measured_angle);
			gyro = s64'(w.measured_rate);
			dt = s64'({40'd0, w.time_step});
			qa = s64'({24'd0, q_angle, 8'd0});
			qb = s64'({24'd0, q_bias, 8'd0});
			rm = s64'({24'd0, r_meas, 8'd0});
			k0 = 0;
			k1 = 0;

			// predict
			rate = clamp(s65'(gyro) - s65'(bias_est), 32);
			angle_est = clamp(s65'(angle_est) + s65'(mul_shift(dt, rate, DT_FRAC)), 32);
			dtp = mul_shift(dt, cov[3], DT_FRAC);
			t = sadd(ssub(ssub(dtp, cov[1]), cov[2]), qa);
			cov[0] = clamp(s65'(sadd(cov[0], mul_shift(dt, t, DT_FRAC))), DEF_COV_WIDTH);
			cov[1] = clamp(s65'(ssub(cov[1], dtp)), DEF_COV_WIDTH);
			cov[2] = clamp(s65'(ssub(cov[2], dtp)), DEF_COV_WIDTH);
			cov[3] = clamp(s65'(sadd(cov[3], mul_shift(qb, dt, DT_FRAC))), DEF_COV_WIDTH);

			// gain
			s = sadd(cov[0], rm);
			if (s != 0) begin
				k0 = div_shift(cov[0], s, GAIN_FRAC);
				k1 = div_shift(cov[2], s, GAIN_FRAC);
			end

			// correct, with covariance terms taken before the update
			y = z - angle_est;
			angle_est = clamp(s65'(sadd(angle_est, mul_shift(k0, y, GAIN_FRAC))), 32);
			bias_est = clamp(s65'(sadd(bias_est, mul_shift(k1, y, GAIN_FRAC))), 32);
			a00 = cov[0];
			a01 = cov[1];
			cov[0] = clamp(s65'(ssub(cov[0], mul_shift(k0, a00, GAIN_FRAC))), DEF_COV_WIDTH);
			cov[1] = clamp(s65'(ssub(cov[1], mul_shift(k0, a01, GAIN_FRAC))), DEF_COV_WIDTH);
			cov[2] = clamp(s65'(ssub(cov[2], mul_shift(k1, a00, GAIN_FRAC))), DEF_COV_WIDTH);
			cov[3] = clamp(s65'(ssub(cov[3], mul_shift(k1, a01, GAIN_FRAC))), DEF_COV_WIDTH);

			res.angle_estimate = angle_est[31:0];
			res.corrected_rate = rate[31:0];
			pending.push_back(res);
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (pending.size() == 0) begin
				$error("unexpected result word angle %h rate %h",
					got.angle_estimate, got.corrected_rate);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.angle_estimate !== want.angle_estimate) begin
				$error("angle_estimate: expected %h, got %h",
					want.angle_estimate, got.angle_estimate);
				errors++;
			end
			if (got.corrected_rate !== want.corrected_rate) begin
				$error("corrected_rate: expected %h, got %h",
					want.corrected_rate, got.corrected_rate);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	tilt_scoreboard sb;
	bit no_idle;
	bit hold_long;

	kalman_angle_bias_filter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_len();
		if (no_idle) return 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 0;
			4, 5, 6, 7: return $urandom_range(1, 3);
			8: return $urandom_range(4, 10);
			default: return $urandom_range(20, 60);
		endcase
	endfunction

	task automatic send_word(in_word_t w);
		repeat (gap_len()) @(negedge clk);
		in_valid = 1'b1;
		in_data = w;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_input(w);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic in_word_t rand_word();
		in_word_t w;
		case ($urandom_range(0, 9))
			0, 1: begin
				w.measured_angle = $urandom;
				w.measured_rate = $urandom;
				w.time_step = 24'($urandom);
			end
			2: begin
				w.measured_angle = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
				w.measured_rate = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
				w.time_step = $urandom_range(0, 1) ? 24'hffffff : 24'($urandom);
			end
			default: begin
				// plausible tilt and gyro samples, angle within +/-100 and rate within +/-250
				w.measured_angle = $signed($urandom_range(0, 200 << 20)) - (100 << 20);
				w.measured_rate = $signed($urandom_range(0, 500 << 20)) - (250 << 20);
				w.time_step = 24'($urandom_range(0, 80000));
			end
		endcase
		return w;
	endfunction

	task automatic run_random(int n);
		repeat (n) send_word(rand_word());
	endtask

	initial begin
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_long) begin
				out_stall = 1'b1;
				repeat (2000) @(negedge clk);
				hold_long = 1'b0;
			end else if (no_idle) begin
				out_stall = 1'b0;
				@(negedge clk);
			end else begin
				out_stall = 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
				out_stall = 1'b1;
				repeat (gap_len()) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	initial begin
		#20ms;
		$display("** kalman_angle_bias_filter: FAILED **");
		$finish;
	end

	initial begin
		in_word_t w;
		sb = new();
		no_idle = 1'b0;
		hold_long = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ANGLE_NOISE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero innovation variance on the first sample
		write_reg(CFG_MEAS_NOISE, 32'd0);
		w.measured_angle = 32'sd5 << 20;
		w.measured_rate = 32'sd3 << 20;
		w.time_step = 24'd0;
		send_word(w);
		drain();
		write_reg(CFG_NO_REG, 32'hdeadbeef);
		write_reg(CFG_MEAS_NOISE, RST_MEAS_NOISE);

		// field extremes
		w = '{32'sh7fffffff, 32'sh7fffffff, 24'hffffff};
		send_word(w);
		w = '{32'sh80000000, 32'sh80000000, 24'hffffff};
		send_word(w);
		w = '{32'sh80000000, 32'sh7fffffff, 24'h000001};
		send_word(w);
		w = '{32'sh7fffffff, 32'sh80000000, 24'h800000};
		send_word(w);
		w = '{32'sd0, 32'sd0, 24'd0};
		send_word(w);
		w = '{32'sh55555555, 32'shaaaaaaaa, 24'h555555};
		send_word(w);
		w = '{32'shaaaaaaaa, 32'sh55555555, 24'haaaaaa};
		send_word(w);
		w = '{-32'sd1, -32'sd1, 24'd10000};
		send_word(w);
		for (int i = 0; i < 12; i++) begin
			w = '{32'sd30 << 20, 32'sd2 << 20, 24'd16777};
			send_word(w);
		end
		drain();

		// every noise at its maximum
		write_reg(CFG_ANGLE_NOISE, 32'hffffffff);
		write_reg(CFG_BIAS_NOISE, 32'hffffffff);
		write_reg(CFG_MEAS_NOISE, 32'hffffffff);
		hold_long = 1'b1;
		run_random(150);
		drain();

		// no process noise at all
		write_reg(CFG_ANGLE_NOISE, 32'd0);
		write_reg(CFG_BIAS_NOISE, 32'd0);
		write_reg(CFG_MEAS_NOISE, $urandom);
		run_random(140);
		drain();

		// random noises, no gaps on either side
		write_reg(CFG_ANGLE_NOISE, $urandom);
		write_reg(CFG_BIAS_NOISE, $urandom);
		write_reg(CFG_MEAS_NOISE, $urandom);
		no_idle = 1'b1;
		run_random(130);
		drain();
		no_idle = 1'b0;

		// back to the default tuning
		write_reg(CFG_ANGLE_NOISE, RST_ANGLE_NOISE);
		write_reg(CFG_BIAS_NOISE, RST_BIAS_NOISE);
		write_reg(CFG_MEAS_NOISE, RST_MEAS_NOISE);
		run_random(260);

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0) begin
			$display("** kalman_angle_bias_filter: PASSED **");
		end else begin
			$display("** kalman_angle_bias_filter: FAILED **");
		end
		$finish;
	end

endmodule
